/* hdl/ocl_pkg.sv */
// Shared constants, types and helper functions of the ordered character list engine.
`default_nettype none

package ocl_pkg;

    // List storage geometry
    localparam int CAPACITY     = 16;
    localparam int ADDR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int SUM_W        = CNT_W + 1;
    localparam int MAX_RESULTS  = 16;

    // Payload widths
    localparam int FUNC_W       = 3;
    localparam int VALUE_W      = 8;
    localparam int STATUS_W     = 2;
    localparam int LIST_COUNT_W = 5;
    localparam int LIST_COUNT_MAX = 31;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH     = 3'd0,
        FUNC_REMOVE   = 3'd1,
        FUNC_READ_FWD = 3'd2,
        FUNC_READ_REV = 3'd3,
        FUNC_CLEAR    = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_REMOVE = 2'd1,
        S_READ   = 2'd2,
        S_RESP   = 2'd3
    } ocl_state_t;

    // Map a list position to a store address relative to the front pointer
    function automatic logic [ADDR_W-1:0] ocl_phys(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0]  pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Saturate the entry count to the width of the reported count
    function automatic logic [LIST_COUNT_W-1:0] ocl_count_field(input logic [CNT_W-1:0] cnt);
        logic [LIST_COUNT_W-1:0] res;
        if (32'(cnt) > 32'(LIST_COUNT_MAX))
        begin
            res = LIST_COUNT_W'(LIST_COUNT_MAX);
        end
        else
        begin
            res = LIST_COUNT_W'(cnt);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hdl/ocl_if.sv */
// Request and result channel interfaces of the ordered character list engine.
`default_nettype none

interface ocl_req_if
    import ocl_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [VALUE_W-1:0]   value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface ocl_rsp_if
    import ocl_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [VALUE_W-1:0]       item_value;
    logic                     is_last;
    logic [STATUS_W-1:0]      status;
    logic [LIST_COUNT_W-1:0]  list_count;

    modport source (output valid, output item_value, output is_last, output status,
                    output list_count, input ready);
    modport sink   (input valid, input item_value, input is_last, input status,
                    input list_count, output ready);
endinterface

`default_nettype wire

/* hdl/ordered_char_list_engine_core.sv */
// Top level of the ordered character list engine: request decode, list walk and result register.
//
// The list lives in a RAM of CAPACITY bytes used as a ring, with a front pointer and an entry
// count in flip-flops; push front only moves the pointer, so a push shifts no entry. One
// request is served at a time. Push, clear and unused codes are decoded in the idle state,
// and the result register is loaded from the response state. Remove walks the list through
// the single RAM read port, one entry per cycle, and compacts survivors through the write
// port, ending with the last read word, the final count update and the result load. A read
// streams min(count, 16) results at one per cycle while the sink keeps taking them; the RAM
// read port sets that pace. A finished result waits in its output register while the block
// already takes the next request. No clearing pass is needed after reset.
`default_nettype none

module ordered_char_list_engine_core
    import ocl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ocl_req_if.sink     req,
    ocl_rsp_if.source   rsp
);

    ocl_state_t              state_reg, state_next;
    func_t                   op_reg, op_next;
    logic [VALUE_W-1:0]      key_reg, key_next;
    logic [ADDR_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]        wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]        total_reg, total_next;
    status_t                 status_reg, status_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic                    rd_last_reg, rd_last_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]      out_item_reg, out_item_next;
    logic                    out_last_reg, out_last_next;
    status_t                 out_status_reg, out_status_next;
    logic [LIST_COUNT_W-1:0] out_count_reg, out_count_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [VALUE_W-1:0]      ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [VALUE_W-1:0]      ram_rdata;

    logic                    out_free;
    logic                    move;
    logic                    issue;
    logic [CNT_W-1:0]        rd_pos;
    logic [ADDR_W-1:0]       head_dec;
    func_t                   req_func;

    ocl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign req_func       = func_t'(req.func);
    assign rsp.valid      = out_valid_reg;
    assign rsp.item_value = out_item_reg;
    assign rsp.is_last    = out_last_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.list_count = out_count_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign head_dec = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - 1'b1;

    // Pick the list position to read: reverse reads walk from the back
    assign rd_pos = (op_reg == FUNC_READ_REV) ? (count_reg - 1'b1 - rd_idx_reg) : rd_idx_reg;

    // Next state, store access and result register
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        total_next      = total_reg;
        status_next     = status_reg;
        rd_vld_next     = rd_vld_reg;
        rd_last_next    = rd_last_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_item_next   = out_item_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_dec;
        ram_wdata       = req.value;
        ram_re          = 1'b0;
        ram_raddr       = ocl_phys(head_reg, rd_pos);
        move            = 1'b0;
        issue           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req_func;
                    key_next    = req.value;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    status_next = STAT_OK;
                    state_next  = S_RESP;
                    case (req_func)
                        FUNC_PUSH:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                head_next  = head_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            state_next = S_REMOVE;
                        end
                        FUNC_READ_FWD, FUNC_READ_REV:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                total_next = (32'(count_reg) > 32'(MAX_RESULTS)) ?
                                             CNT_W'(MAX_RESULTS) : count_reg;
                                state_next = S_READ;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end

            S_REMOVE:
            begin
                // Keep entries that differ from the key, packed toward the front
                if (rd_vld_reg && (ram_rdata != key_reg))
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = ocl_phys(head_reg, wr_idx_reg);
                    ram_wdata   = ram_rdata;
                    wr_idx_next = wr_idx_reg + 1'b1;
                end
                issue = (rd_idx_reg < count_reg);
                if (issue)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                rd_vld_next = issue;
                if (!issue && !rd_vld_reg)
                begin
                    count_next  = wr_idx_reg;
                    status_next = (wr_idx_reg == count_reg) ? STAT_NOT_FOUND : STAT_OK;
                    state_next  = S_RESP;
                end
            end

            S_READ:
            begin
                // Advance the read word into the result register when it is free
                move = rd_vld_reg && out_free;
                if (move)
                begin
                    out_valid_next  = 1'b1;
                    out_item_next   = ram_rdata;
                    out_last_next   = rd_last_reg;
                    out_status_next = STAT_OK;
                    out_count_next  = ocl_count_field(count_reg);
                end
                issue = (rd_idx_reg < total_reg) && (!rd_vld_reg || move);
                if (issue)
                begin
                    ram_re       = 1'b1;
                    rd_last_next = (rd_idx_reg == total_reg - 1'b1);
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
                rd_vld_next = issue || (rd_vld_reg && !move);
                if (move && rd_last_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_item_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = ocl_count_field(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        total_reg      <= total_next;
        status_reg     <= status_next;
        rd_last_reg    <= rd_last_next;
        out_item_reg   <= out_item_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // The compaction write never overtakes the read walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |-> (wr_idx_reg <= rd_idx_reg))
        else $error("remove write index passed read index");

    // A store write and read never hit the same entry in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("store read and write collide");

    // A request is taken only with no read word in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !rd_vld_reg)
        else $error("request accepted during a list walk");

    // A push into a list with room grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req_func == FUNC_PUSH) &&
         (count_reg != CNT_W'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the list");

    // The entry count, and the read total during a read, never exceed the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) <= 32'(CAPACITY)) && (32'(total_reg) <= 32'(CAPACITY) ||
         state_reg != S_READ))
        else $error("entry count beyond capacity");

endmodule

`default_nettype wire

/* hdl/ocl_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module ocl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: hold the last word while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* test/ocl_list_checker.sv */
// Scoreboard of the list engine: mirrors the list contents and checks every result transfer.
module ocl_list_checker
    import ocl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ocl_req_if        req,
    ocl_rsp_if        rsp,
    output int        fail_count,
    output int        due_count,
    output int        request_count,
    output int        result_count
);

    typedef struct packed {
        logic [VALUE_W-1:0]      item_value;
        logic                    is_last;
        status_t                 status;
        logic [LIST_COUNT_W-1:0] list_count;
    } list_result_t;

    // Mirror of the list, front at index 0
    logic [VALUE_W-1:0] mirror_list [CAPACITY];
    int                 mirror_len;
    list_result_t       results_due [$];
    int                 fails;
    int                 requests_seen;
    int                 results_seen;

    // Reported count saturates at the width of the list_count field
    function automatic logic [LIST_COUNT_W-1:0] len_field(input int len);
        if (len > LIST_COUNT_MAX)
        begin
            return LIST_COUNT_W'(LIST_COUNT_MAX);
        end
        return LIST_COUNT_W'(len);
    endfunction

    task automatic queue_result(input logic [VALUE_W-1:0] item, input logic last,
                                input status_t stat);
        list_result_t res;
        res.item_value = item;
        res.is_last    = last;
        res.status     = stat;
        res.list_count = len_field(mirror_len);
        results_due.push_back(res);
    endtask

    // Apply one request to the mirror and queue the results it causes
    task automatic advance_list(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] key);
        int i;
        int keep;
        int old_len;
        int n;
        int idx;
        case (op)
            FUNC_PUSH:
            begin
                if (mirror_len >= CAPACITY)
                begin
                    queue_result('0, 1'b1, STAT_FULL);
                end
                else
                begin
                    for (i = mirror_len; i > 0; i--)
                    begin
                        mirror_list[i] = mirror_list[i-1];
                    end
                    mirror_list[0] = key;
                    mirror_len++;
                    queue_result('0, 1'b1, STAT_OK);
                end
            end
            FUNC_REMOVE:
            begin
                // Compact survivors toward the front, keeping their order
                keep = 0;
                for (i = 0; i < mirror_len; i++)
                begin
                    if (mirror_list[i] != key)
                    begin
                        mirror_list[keep] = mirror_list[i];
                        keep++;
                    end
                end
                old_len    = mirror_len;
                mirror_len = keep;
                queue_result('0, 1'b1, (keep == old_len) ? STAT_NOT_FOUND : STAT_OK);
            end
            FUNC_READ_FWD, FUNC_READ_REV:
            begin
                if (mirror_len == 0)
                begin
                    queue_result('0, 1'b1, STAT_EMPTY);
                end
                else
                begin
                    n = (mirror_len > MAX_RESULTS) ? MAX_RESULTS : mirror_len;
                    for (i = 0; i < n; i++)
                    begin
                        idx = (op == FUNC_READ_FWD) ? i : mirror_len - 1 - i;
                        queue_result(mirror_list[idx], i == n - 1, STAT_OK);
                    end
                end
            end
            FUNC_CLEAR:
            begin
                mirror_len = 0;
                queue_result('0, 1'b1, STAT_OK);
            end
            default:
            begin
                queue_result('0, 1'b1, STAT_OK);
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Watch both channels; the result transfer is taken first since it belongs to an older request
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            mirror_len    = 0;
            results_due.delete();
            fails         = 0;
            requests_seen = 0;
            results_seen  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (results_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: result transfer with nothing outstanding, item %0d status %0d",
                             $time, rsp.item_value, rsp.status);
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("item_value", want.item_value, rsp.item_value);
                    check_field("is_last", want.is_last, rsp.is_last);
                    check_field("status", want.status, rsp.status);
                    check_field("list_count", want.list_count, rsp.list_count);
                end
            end
            if (req.valid && req.ready)
            begin
                requests_seen++;
                advance_list(req.func, req.value);
            end
        end
        fail_count    <= fails;
        due_count     <= results_due.size();
        request_count <= requests_seen;
        result_count  <= results_seen;
    end

endmodule

/* test/tb_ordered_char_list_engine_core.sv */
// Testbench top of the list engine: clock, reset, request stimulus, result stalls and verdict.
module tb_ordered_char_list_engine_core;
    import ocl_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 183;
    localparam int HOLD_AT_ITEM = 40;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic hold_request;
    logic hold_done;
    int   burst_left;
    int   fail_count;
    int   due_count;
    int   request_count;
    int   result_count;

    ocl_req_if req_ch ();
    ocl_rsp_if rsp_ch ();

    ordered_char_list_engine_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ocl_list_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .request_count (request_count),
        .result_count  (result_count)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request and hold it until the transfer; valid stays high afterwards
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] val);
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.value <= val;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Close a burst with a random gap, or keep offering back to back
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42)
        begin
            return FUNC_PUSH;
        end
        if (r < 60)
        begin
            return FUNC_REMOVE;
        end
        if (r < 75)
        begin
            return FUNC_READ_FWD;
        end
        if (r < 90)
        begin
            return FUNC_READ_REV;
        end
        if (r < 96)
        begin
            return FUNC_CLEAR;
        end
        return FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
    endfunction

    // Mostly a narrow pool so removes find matches and duplicates pile up
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return VALUE_W'($urandom_range(0, 3));
        end
        if (r < 7)
        begin
            return VALUE_W'($urandom_range(252, 255));
        end
        return VALUE_W'($urandom_range(0, 255));
    endfunction

    // Stall results in changing patterns, with one long hold-off on request
    initial
    begin : result_sink
        int mode;
        int span;
        mode = 0;
        span = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(16, 80);
                end
                span--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // End the run when no transfer happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        logic [VALUE_W-1:0] fill_val;
        hold_request = 1'b0;
        burst_left   = 0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FUNC_PUSH;
        req_ch.value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Operate on the empty list, including spare codes
        send_request(FUNC_READ_FWD, 8'h00);
        pace_sender();
        send_request(FUNC_READ_REV, 8'hFF);
        pace_sender();
        send_request(FUNC_REMOVE, 8'h3C);
        pace_sender();
        send_request(FUNC_SPARE_LO, 8'hFF);
        pace_sender();
        send_request(FUNC_SPARE_HI, 8'h00);
        pace_sender();
        send_request(FUNC_CLEAR, 8'hFF);
        pace_sender();

        // Fill to capacity with the extremes and a repeated byte
        for (i = 0; i < CAPACITY; i++)
        begin
            fill_val = (i % 4 == 1) ? 8'hA5 : VALUE_W'(i * 17);
            send_request(FUNC_PUSH, fill_val);
            pace_sender();
        end
        send_request(FUNC_PUSH, 8'h5A);
        pace_sender();
        send_request(FUNC_READ_FWD, 8'h00);
        pace_sender();
        send_request(FUNC_READ_REV, 8'h00);
        pace_sender();
        send_request(FUNC_REMOVE, 8'hA5);
        pace_sender();
        send_request(FUNC_CLEAR, 8'h00);
        pace_sender();

        // Random traffic; partway in, stall results long enough to back up requests
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_AT_ITEM)
            begin
                hold_request = 1'b1;
            end
            send_request(pick_func(), pick_value());
            pace_sender();
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding results, then allow for the block's latency
        @(posedge clk);
        while (due_count != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d result transfers: empty, full, duplicate removal,",
                 request_count, result_count);
        $display("both read directions, spare codes, random idling and one long result stall.");
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/ocl_pkg.sv
hdl/ocl_if.sv
hdl/ocl_ram.sv
hdl/ordered_char_list_engine_core.sv
test/ocl_list_checker.sv
test/tb_ordered_char_list_engine_core.sv
